// ----- hw/rtl/mau_pkg.sv -----
// Package for the modular arithmetic unit: payload types, codes, commands.
package mau_pkg;

  localparam int unsigned Width = 31;
  localparam int unsigned WideW = 64;
  localparam logic [61:0] ModReset = 62'd1000000007;

  typedef enum logic [2:0] {
    FN_REDUCE = 3'd0,
    FN_ADD    = 3'd1,
    FN_SUB    = 3'd2,
    FN_MUL    = 3'd3,
    FN_DIV    = 3'd4,
    FN_INC    = 3'd5,
    FN_DEC    = 3'd6,
    FN_NEG    = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0]        func;
    logic [Width-1:0]  operand_a;
    logic [Width-1:0]  operand_b;
    logic signed [WideW-1:0] wide_value;
  } req_t;

  typedef struct packed {
    logic [Width-1:0] result;
    logic             error;
  } rsp_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,  // capture request, start reducing a, b, wide
    CMD_DIVSTP = 4'd2,  // one bit of the running restoring division
    CMD_SIMPLE = 4'd3,  // form add/sub/inc/dec/neg/reduce result
    CMD_MULINI = 4'd4,  // start modular multiply x*y
    CMD_MULSTP = 4'd5,  // one bit of shift-and-add
    CMD_EINI   = 4'd6,  // start Euclid: r0=m, r1=b, t0=0, t1=1
    CMD_EDIV   = 4'd7,  // start division r0 / r1
    CMD_EMUL   = 4'd8,  // start q*t1 mod m
    CMD_EUPD   = 4'd9,  // finish one Euclid step
    CMD_DMUL   = 4'd10, // start a*inv
    CMD_ERR    = 4'd11  // result 0, error 1
  } cmd_e;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic r1_zero;
    logic r0_one;
    logic b_zero;
    logic m_small;
    logic [2:0] func;
  } sts_t;

endpackage

// ----- hw/rtl/mau_datapath.sv -----
// Datapath: operand registers, shared bit-serial divider and modular multiplier.
module mau_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mau_pkg::cmd_e             cmd_i,
  input  logic [mau_pkg::Width-1:0] modulus_i,
  input  mau_pkg::req_t             req_i,
  output mau_pkg::sts_t             sts_o,
  output logic [mau_pkg::Width-1:0] result_o,
  output logic                      error_o
);
  localparam int unsigned WIDTH = mau_pkg::Width;
  localparam int unsigned DW = 64;            // dividend width
  localparam int unsigned CW = $clog2(DW + 1);
  localparam int unsigned MW = $clog2(WIDTH + 1);

  logic [2:0]       func_q, func_d;
  logic [WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic             neg_q, neg_d;
  logic [DW-1:0]    w_q, w_d;             // wide magnitude
  // divider
  logic [DW-1:0]    dq_q, dq_d;           // dividend shifting to quotient
  logic [WIDTH:0]   dr_q, dr_d;           // partial remainder
  logic [WIDTH-1:0] dv_q, dv_d;           // divisor
  logic [CW-1:0]    dc_q, dc_d;
  logic [1:0]       dph_q, dph_d;         // which reduction is running
  // multiplier
  logic [WIDTH-1:0] mx_q, mx_d, my_q, my_d, macc_q, macc_d;
  logic [MW-1:0]    mc_q, mc_d;
  // Euclid
  logic [WIDTH-1:0] r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             err_q, err_d;

  logic [WIDTH:0]   trial, tsub;

  function automatic logic [WIDTH-1:0] addm(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
    logic [WIDTH:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] subm(input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  always_comb begin
    trial = {dr_q[WIDTH-1:0], dq_q[DW-1]};
    tsub  = trial - {1'b0, dv_q};
    func_d = func_q; a_d = a_q; b_d = b_q; neg_d = neg_q; w_d = w_q;
    dq_d = dq_q; dr_d = dr_q; dv_d = dv_q; dc_d = dc_q; dph_d = dph_q;
    mx_d = mx_q; my_d = my_q; macc_d = macc_q; mc_d = mc_q;
    r0_d = r0_q; r1_d = r1_q; t0_d = t0_q; t1_d = t1_q;
    res_d = res_q; err_d = err_q;
    case (cmd_i)
      mau_pkg::CMD_LOAD: begin
        func_d = req_i.func;
        neg_d  = req_i.wide_value[DW-1];
        w_d    = neg_d ? (~req_i.wide_value) + 64'd1 : req_i.wide_value;
        dph_d  = 2'd0;
        dq_d   = {{(DW-WIDTH){1'b0}}, req_i.operand_a[WIDTH-1:0]};
        b_d    = req_i.operand_b[WIDTH-1:0];
        dr_d = '0; dv_d = modulus_i; dc_d = CW'(DW);
        err_d = 1'b0;
      end
      mau_pkg::CMD_DIVSTP: begin
        if (!tsub[WIDTH]) begin
          dr_d = tsub;
          dq_d = {dq_q[DW-2:0], 1'b1};
        end else begin
          dr_d = trial;
          dq_d = {dq_q[DW-2:0], 1'b0};
        end
        dc_d = dc_q - 1'b1;
        // chain the three reductions a, b, wide
        if (dc_q == CW'(1) && dph_q != 2'd3) begin
          case (dph_q)
            2'd0: begin
              a_d = dr_d[WIDTH-1:0]; dph_d = 2'd1;
              dq_d = {{(DW-WIDTH){1'b0}}, b_q}; dr_d = '0; dc_d = CW'(DW);
            end
            2'd1: begin
              b_d = dr_d[WIDTH-1:0]; dph_d = 2'd2;
              dq_d = w_q; dr_d = '0; dc_d = CW'(DW);
            end
            default: begin
              w_d = {{(DW-WIDTH){1'b0}}, dr_d[WIDTH-1:0]}; dph_d = 2'd3;
            end
          endcase
        end
      end
      mau_pkg::CMD_SIMPLE: begin
        case (mau_pkg::func_e'(func_q))
          mau_pkg::FN_REDUCE: res_d = (neg_q && w_q[WIDTH-1:0] != '0) ?
                                modulus_i - w_q[WIDTH-1:0] : w_q[WIDTH-1:0];
          mau_pkg::FN_ADD: res_d = addm(a_q, b_q, modulus_i);
          mau_pkg::FN_SUB: res_d = subm(a_q, b_q, modulus_i);
          mau_pkg::FN_INC: res_d = addm(a_q, WIDTH'(1), modulus_i);
          mau_pkg::FN_DEC: res_d = subm(a_q, WIDTH'(1), modulus_i);
          mau_pkg::FN_NEG: res_d = subm('0, a_q, modulus_i);
          default: res_d = macc_q;
        endcase
      end
      mau_pkg::CMD_MULINI: begin
        mx_d = a_q; my_d = b_q; macc_d = '0; mc_d = MW'(WIDTH);
      end
      mau_pkg::CMD_DMUL: begin
        mx_d = a_q; my_d = t0_q; macc_d = '0; mc_d = MW'(WIDTH);
      end
      mau_pkg::CMD_EMUL: begin
        // quotient <= m here since r1 >= 1 and r0 <= m
        mx_d = t1_q; my_d = dq_q[WIDTH-1:0]; macc_d = '0; mc_d = MW'(WIDTH);
      end
      mau_pkg::CMD_MULSTP: begin
        if (my_q[0]) macc_d = addm(macc_q, mx_q, modulus_i);
        mx_d = addm(mx_q, mx_q, modulus_i);
        my_d = my_q >> 1;
        mc_d = mc_q - 1'b1;
      end
      mau_pkg::CMD_EINI: begin
        r0_d = modulus_i; r1_d = b_q; t0_d = '0; t1_d = WIDTH'(1);
      end
      mau_pkg::CMD_EDIV: begin
        dq_d = {{(DW-WIDTH){1'b0}}, r0_q}; dr_d = '0; dv_d = r1_q;
        dc_d = CW'(DW); dph_d = 2'd3;
      end
      mau_pkg::CMD_EUPD: begin
        r0_d = r1_q; r1_d = dr_q[WIDTH-1:0];
        t0_d = t1_q; t1_d = subm(t0_q, macc_q, modulus_i);
      end
      mau_pkg::CMD_ERR: begin
        res_d = '0; err_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= '0; mc_q <= '0; dph_q <= 2'd3; err_q <= 1'b0;
    end else begin
      dc_q <= dc_d; mc_q <= mc_d; dph_q <= dph_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d; a_q <= a_d; b_q <= b_d; neg_q <= neg_d; w_q <= w_d;
    dq_q <= dq_d; dr_q <= dr_d; dv_q <= dv_d;
    mx_q <= mx_d; my_q <= my_d; macc_q <= macc_d;
    r0_q <= r0_d; r1_q <= r1_d; t0_q <= t0_d; t1_q <= t1_d;
    res_q <= res_d;
  end

  assign sts_o.div_done = (dc_q == '0);
  assign sts_o.mul_done = (mc_q == '0);
  assign sts_o.r1_zero  = (r1_q == '0);
  assign sts_o.r0_one   = (r0_q == WIDTH'(1));
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.m_small  = (modulus_i < WIDTH'(2));
  assign sts_o.func     = func_q;
  assign result_o = res_q;
  assign error_o  = err_q;
endmodule

// ----- hw/rtl/mau_ctrl.sv -----
// Controller: sequences reduction, multiply and Euclid steps for one request.
module mau_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mau_pkg::sts_t sts_i,
  output mau_pkg::cmd_e cmd_o,
  output logic          zero_o
);
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RED   = 10'b0000000010,
    ST_MUL   = 10'b0000000100,
    ST_EDIV  = 10'b0000001000,
    ST_EMUL  = 10'b0000010000,
    ST_EUPD  = 10'b0000100000,
    ST_DMUL  = 10'b0001000000,
    ST_EDEC  = 10'b0010000000,
    ST_SET   = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   zero_q, zero_d;

  always_comb begin
    state_d = state_q; zero_d = zero_q;
    cmd_o = mau_pkg::CMD_NONE;
    in_stall = (state_q != ST_IDLE);
    out_valid = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid) begin
        cmd_o = mau_pkg::CMD_LOAD; zero_d = sts_i.m_small; state_d = ST_RED;
      end
      ST_RED: begin
        if (!sts_i.div_done) cmd_o = mau_pkg::CMD_DIVSTP;
        else if (zero_q) begin
          state_d = ST_OUT;
        end else case (mau_pkg::func_e'(sts_i.func))
          mau_pkg::FN_MUL: begin
            cmd_o = mau_pkg::CMD_MULINI; state_d = ST_MUL;
          end
          mau_pkg::FN_DIV: begin
            if (sts_i.b_zero) begin cmd_o = mau_pkg::CMD_ERR; state_d = ST_OUT; end
            else begin cmd_o = mau_pkg::CMD_EINI; state_d = ST_EDEC; end
          end
          default: begin cmd_o = mau_pkg::CMD_SIMPLE; state_d = ST_OUT; end
        endcase
      end
      ST_EDEC: begin
        if (!sts_i.r1_zero) begin cmd_o = mau_pkg::CMD_EDIV; state_d = ST_EDIV; end
        else if (sts_i.r0_one) begin cmd_o = mau_pkg::CMD_DMUL; state_d = ST_DMUL; end
        else begin cmd_o = mau_pkg::CMD_ERR; state_d = ST_OUT; end
      end
      ST_EDIV: begin
        if (!sts_i.div_done) cmd_o = mau_pkg::CMD_DIVSTP;
        else begin cmd_o = mau_pkg::CMD_EMUL; state_d = ST_EMUL; end
      end
      ST_EMUL: begin
        if (!sts_i.mul_done) cmd_o = mau_pkg::CMD_MULSTP;
        else begin cmd_o = mau_pkg::CMD_EUPD; state_d = ST_EDEC; end
      end
      ST_DMUL: begin
        if (!sts_i.mul_done) cmd_o = mau_pkg::CMD_MULSTP;
        else begin cmd_o = mau_pkg::CMD_SIMPLE; state_d = ST_SET; end
      end
      ST_MUL: begin
        if (!sts_i.mul_done) cmd_o = mau_pkg::CMD_MULSTP;
        else begin cmd_o = mau_pkg::CMD_SIMPLE; state_d = ST_SET; end
      end
      ST_SET: state_d = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; zero_q <= 1'b0;
    end else begin
      state_q <= state_d; zero_q <= zero_d;
    end
  end

  assign zero_o = zero_q;
endmodule

// ----- hw/rtl/modular_arithmetic_unit.sv -----
// Modular arithmetic unit: one result per request over a configured modulus.
// Bit-serial reduction of a, b and the wide value in turn, then the result is formed
// for add/sub/inc/dec/neg/reduce, after a shift-and-add multiply for mul; div runs
// one division and one multiply per Euclid step, plus a final multiply.
// One request at a time; the next is taken after the result is delivered.
// Reset: modulus returns to 1000000007 masked to WIDTH bits, controller idles.
module modular_arithmetic_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mau_pkg::req_t             in_data_i,
  output logic                      out_valid,
  input  logic                      out_stall,
  output mau_pkg::rsp_t             out_data_o,
  input  logic                      cfg_we_i,
  input  logic [mau_pkg::Width-1:0] cfg_wdata_i
);
  localparam int unsigned WIDTH = mau_pkg::Width;

  logic [WIDTH-1:0] mod_q;
  mau_pkg::cmd_e    cmd;
  mau_pkg::sts_t    sts;
  logic             zero;
  logic [WIDTH-1:0] res;
  logic             err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= mau_pkg::ModReset[WIDTH-1:0];
    else if (cfg_we_i) mod_q <= cfg_wdata_i;
  end

  mau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts_i(sts), .cmd_o(cmd), .zero_o(zero)
  );

  mau_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .modulus_i(mod_q), .req_i(in_data_i),
    .sts_o(sts), .result_o(res), .error_o(err)
  );

  assign out_data_o.result = zero ? '0 : res;
  assign out_data_o.error  = zero ? 1'b0 : err;
endmodule

// ----- sim/modular_arithmetic_unit_tb.sv -----
// Testbench for the modular arithmetic unit: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module modular_arithmetic_unit_tb;

  localparam int unsigned W = mau_pkg::Width;
  localparam longint unsigned LIMIT = 64'd40_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mau_pkg::req_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  mau_pkg::rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [W-1:0] cfg_wdata_i = '0;

  modular_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  mau_pkg::req_t pending_q[$];
  mau_pkg::rsp_t expected_q[$];
  logic [63:0] cur_mod;
  int errors = 0;
  longint unsigned cycles = 0;
  int drv_gap = 0;
  int mon_gap = 0;
  int hold_cycles = 0;
  bit hold_go = 0;
  bit hold_used = 0;

  function automatic logic [63:0] madd(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] s;
    s = x + y;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic logic [63:0] msub(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  function automatic logic [63:0] mmul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] r;
    r = '0;
    x = x % m;
    while (y != 0) begin
      if (y[0]) r = madd(r, x, m);
      x = madd(x, x, m);
      y = y >> 1;
    end
    return r;
  endfunction

  // result and error of one request under modulus m
  function automatic mau_pkg::rsp_t modular_result(mau_pkg::req_t rq, logic [63:0] m);
    logic [63:0] a, b, r0, r1, t0, t1, q, r2, t2, res, mag, v;
    mau_pkg::rsp_t o;
    res = '0;
    o.error = 1'b0;
    if (m >= 2) begin
      a = 64'(rq.operand_a) % m;
      b = 64'(rq.operand_b) % m;
      case (mau_pkg::func_e'(rq.func))
        mau_pkg::FN_REDUCE: begin
          v = rq.wide_value;
          if (!v[63]) res = v % m;
          else begin
            mag = (~v) + 64'd1;
            res = (mag % m == 0) ? 64'd0 : m - (mag % m);
          end
        end
        mau_pkg::FN_ADD: res = madd(a, b, m);
        mau_pkg::FN_SUB: res = msub(a, b, m);
        mau_pkg::FN_MUL: res = mmul(a, b, m);
        mau_pkg::FN_DIV: begin
          r0 = m; r1 = b; t0 = 64'd0; t1 = 64'd1;
          while (r1 != 0) begin
            q = r0 / r1;
            r2 = r0 - q * r1;
            t2 = msub(t0, mmul(q % m, t1, m), m);
            r0 = r1; r1 = r2; t0 = t1; t1 = t2;
          end
          if (b != 0 && r0 == 1) res = mmul(a, t0, m);
          else o.error = 1'b1;
        end
        mau_pkg::FN_INC: res = madd(a, 64'd1, m);
        mau_pkg::FN_DEC: res = msub(a, 64'd1, m);
        default: res = msub(64'd0, a, m);
      endcase
    end
    o.result = res[W-1:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(modular_result(in_data_i, cur_mod));
        void'(pending_q.pop_front());
        drv_gap <= $urandom_range(0, 15);
        if (pending_q.size() != 0 && $urandom_range(0, 15) == 0) begin
          in_data_i <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (drv_gap > 0) drv_gap <= drv_gap - 1;
        else if (pending_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data_i <= pending_q[0];
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_cycles <= 3000;
      hold_used <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: %h", out_data_o);
          errors = errors + 1;
        end else begin
          if (out_data_o.result !== expected_q[0].result) begin
            $error("result exp %0d got %0d", expected_q[0].result, out_data_o.result);
            errors = errors + 1;
          end
          if (out_data_o.error !== expected_q[0].error) begin
            $error("error exp %0d got %0d", expected_q[0].error, out_data_o.error);
            errors = errors + 1;
          end
          void'(expected_q.pop_front());
        end
        mon_gap <= $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        out_stall <= 1'b1;
      end else if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic mau_pkg::req_t rand_req(logic [63:0] m, bit unreduced);
    mau_pkg::req_t r;
    r.func = 3'($urandom_range(0, 7));
    if (unreduced || m < 2) begin
      r.operand_a = W'($urandom);
      r.operand_b = W'($urandom);
    end else begin
      r.operand_a = W'(64'({$urandom, $urandom}) % m);
      r.operand_b = W'(64'({$urandom, $urandom}) % m);
    end
    r.wide_value = {$urandom, $urandom};
    return r;
  endfunction

  function automatic mau_pkg::req_t mk(mau_pkg::func_e f, logic [W-1:0] a,
                                       logic [W-1:0] b, logic [63:0] w);
    mau_pkg::req_t r;
    r.func = f; r.operand_a = a; r.operand_b = b; r.wide_value = w;
    return r;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic set_modulus(logic [63:0] m);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m[W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mod <= m & ((64'd1 << W) - 1);
    @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] mods[10];
    logic [W-1:0] mx;
    mods = '{64'd2147483647, 64'd2, 64'd3, 64'd12, 64'd97, 64'd1, 64'd0,
             64'd2147483646, 64'd65536, 64'd1000000007};
    mx = '1;
    cur_mod = 64'd1000000007;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    pending_q.push_back(mk(mau_pkg::FN_REDUCE, '0, '0, 64'h8000000000000000));
    pending_q.push_back(mk(mau_pkg::FN_REDUCE, '0, '0, 64'h7fffffffffffffff));
    pending_q.push_back(mk(mau_pkg::FN_REDUCE, '0, '0, -64'sd1000000007));
    pending_q.push_back(mk(mau_pkg::FN_REDUCE, '0, '0, 64'hffffffffffffffff));
    pending_q.push_back(mk(mau_pkg::FN_ADD, W'(1000000006), W'(1000000006), 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_SUB, '0, W'(1000000006), 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_MUL, W'(1000000006), W'(1000000006), 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_DIV, W'(5), '0, 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_DIV, W'(1000000006), W'(3), 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_DIV, W'(7), W'(1000000007), 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_INC, W'(1000000006), '0, 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_DEC, '0, '0, 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_NEG, '0, '0, 64'd0));
    pending_q.push_back(mk(mau_pkg::FN_NEG, mx, mx, 64'hffffffffffffffff));
    pending_q.push_back(mk(mau_pkg::FN_ADD, mx, mx, 64'd0));
    drain();
    // long receiver hold-off while requests keep coming
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) pending_q.push_back(rand_req(cur_mod, 0));
    drain();
    foreach (mods[k]) begin
      set_modulus(mods[k]);
      for (int i = 0; i < 150; i++) begin
        pending_q.push_back(rand_req(cur_mod, $urandom_range(0, 9) == 0));
        if (cur_mod == 12 && i % 8 == 0)
          pending_q.push_back(mk(mau_pkg::FN_DIV, W'($urandom_range(0, 11)), W'(6), 64'd0));
      end
      drain();
    end
    if (errors == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mau_pkg.sv
hw/rtl/mau_datapath.sv
hw/rtl/mau_ctrl.sv
hw/rtl/modular_arithmetic_unit.sv
sim/modular_arithmetic_unit_tb.sv
